@@ src/keyword_statement_tokenizer_defines.svh @@
// Assertion macros for the keyword/statement tokenizer.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef KEYWORD_STATEMENT_TOKENIZER_DEFINES_SVH
`define KEYWORD_STATEMENT_TOKENIZER_DEFINES_SVH

// same-cycle implication, held off during reset
`define KST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define KST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/kst_pkg.sv @@
// Shared types and constants of the keyword/statement tokenizer.
// No dependencies.
package kst_pkg;

  localparam int KEYWORD_MAX = 255;
  localparam int KLEN_W      = $clog2(KEYWORD_MAX + 1);

  typedef logic [KLEN_W-1:0] klen_t;
  typedef logic [KLEN_W:0]   klen_ext_t;

  localparam logic [7:0] START_RST = 8'd123;  // '{'
  localparam logic [7:0] STOP_RST  = 8'd125;  // '}'

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_STOP  = 1'b1;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SKIP_CMT,
    PH_KEYWORD,
    PH_SEEK,
    PH_SEEK_CMT,
    PH_STMT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_KEYWORD,
    KIND_STMT,
    KIND_END
  } kind_t;

  typedef enum logic [1:0] {
    ST_FULL,
    ST_EMPTY,
    ST_NONE,
    ST_EOT
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    status_t    status;
    logic       last;
  } result_t;

  typedef struct packed {
    phase_t phase;
    logic   quotes;
    klen_t  klen;
  } state_t;

  // results of one input byte: count plus up to two result beats
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } step_t;

endpackage

@@ src/kst_step.sv @@
// Next-state and result logic for one text byte of the tokenizer.
// Depends on kst_pkg.
module kst_step (
  input  kst_pkg::state_t cur,
  input  logic [7:0]      start_char,
  input  logic [7:0]      stop_char,
  input  logic [7:0]      b,
  input  logic            eot,
  output kst_pkg::state_t nxt,
  output kst_pkg::step_t  res
);

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  logic                   is_cmt;
  logic                   is_nl;
  kst_pkg::klen_ext_t     klen_inc;
  logic                   one_is_max;

  assign is_cmt     = (b == kst_pkg::CH_BANG) || (b == kst_pkg::CH_HASH);
  assign is_nl      = (b == kst_pkg::CH_NL);
  assign klen_inc   = kst_pkg::klen_ext_t'(cur.klen) + kst_pkg::klen_ext_t'(1);
  assign one_is_max = (kst_pkg::KEYWORD_MAX <= 1);

  always_comb begin
    logic              seek_go;
    logic              skip_go;
    logic [1:0]        cnt;
    kst_pkg::result_t  r [2];

    seek_go = 1'b0;
    skip_go = 1'b0;
    cnt     = 2'd0;
    r[0]    = '0;
    r[1]    = '0;
    nxt     = cur;

    if (eot) begin
      r[0].kind   = kst_pkg::KIND_END;
      r[0].status = kst_pkg::ST_EOT;
      cnt         = 2'd1;
      nxt.phase   = kst_pkg::PH_SKIP;
      nxt.quotes  = 1'b0;
      nxt.klen    = '0;
    end else begin
      unique case (cur.phase)
        kst_pkg::PH_SKIP_CMT: begin
          if (is_nl) nxt.phase = kst_pkg::PH_SKIP;
        end
        kst_pkg::PH_KEYWORD: begin
          if (is_letter(b) || is_digit(b) || b == kst_pkg::CH_UNDER) begin
            r[cnt[0]].data = upper(b);
            r[cnt[0]].kind = kst_pkg::KIND_KEYWORD;
            cnt            = cnt + 2'd1;
            nxt.klen       = kst_pkg::klen_t'(klen_inc);
            if (klen_inc >= kst_pkg::klen_ext_t'(kst_pkg::KEYWORD_MAX))
              nxt.phase = kst_pkg::PH_SEEK;
          end else begin
            seek_go = 1'b1;  // keyword ends, same byte goes to seek
          end
        end
        kst_pkg::PH_SEEK: seek_go = 1'b1;
        kst_pkg::PH_SEEK_CMT: begin
          if (is_nl) nxt.phase = kst_pkg::PH_SEEK;
        end
        kst_pkg::PH_STMT: begin
          if (b == stop_char && !cur.quotes) begin
            r[cnt[0]].kind   = kst_pkg::KIND_END;
            r[cnt[0]].status = kst_pkg::ST_FULL;
            cnt              = cnt + 2'd1;
            nxt.phase        = kst_pkg::PH_SKIP;
            nxt.quotes       = 1'b0;
            nxt.klen         = '0;
          end else begin
            if (b == kst_pkg::CH_QUOTE) nxt.quotes = !cur.quotes;
            r[cnt[0]].data = b;
            r[cnt[0]].kind = kst_pkg::KIND_STMT;
            cnt            = cnt + 2'd1;
          end
        end
        default: skip_go = 1'b1;
      endcase

      if (seek_go) begin
        nxt.phase = kst_pkg::PH_SEEK;
        priority if (b == start_char) begin
          nxt.phase  = kst_pkg::PH_STMT;
          nxt.quotes = 1'b0;
        end else if (is_blank(b)) begin
          nxt.phase = kst_pkg::PH_SEEK;
        end else if (is_cmt) begin
          nxt.phase = kst_pkg::PH_SEEK_CMT;
        end else if (b == stop_char) begin
          r[cnt[0]].kind   = kst_pkg::KIND_END;
          r[cnt[0]].status = kst_pkg::ST_EMPTY;
          cnt              = cnt + 2'd1;
          nxt.phase        = kst_pkg::PH_SKIP;
          nxt.quotes       = 1'b0;
          nxt.klen         = '0;
        end else begin
          // no statement: close the record, then the byte starts over
          r[cnt[0]].kind   = kst_pkg::KIND_END;
          r[cnt[0]].status = kst_pkg::ST_NONE;
          cnt              = cnt + 2'd1;
          nxt.quotes       = 1'b0;
          nxt.klen         = '0;
          skip_go          = 1'b1;
        end
      end

      if (skip_go) begin
        nxt.phase = kst_pkg::PH_SKIP;
        if (is_letter(b)) begin
          r[cnt[0]].data = upper(b);
          r[cnt[0]].kind = kst_pkg::KIND_KEYWORD;
          cnt            = cnt + 2'd1;
          nxt.klen       = kst_pkg::klen_t'(1);
          nxt.phase      = one_is_max ? kst_pkg::PH_SEEK : kst_pkg::PH_KEYWORD;
        end else if (is_cmt) begin
          nxt.phase = kst_pkg::PH_SKIP_CMT;
        end
      end
    end

    if (cnt == 2'd2)
      r[1].last = 1'b1;
    else if (cnt == 2'd1)
      r[0].last = 1'b1;

    res.n  = cnt;
    res.r0 = r[0];
    res.r1 = r[1];
  end

endmodule

@@ src/kst_obuf.sv @@
// Two-entry result register: holds the beats of one byte until taken.
// Depends on kst_pkg.
module kst_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  kst_pkg::step_t   step,
  input  logic             ready,
  output logic             valid,
  output logic             free,
  output kst_pkg::result_t head
);

  logic [1:0]       cnt_r;
  kst_pkg::result_t a_r;
  kst_pkg::result_t b_r;
  logic             pop;

  assign pop   = (cnt_r != 2'd0) && ready;
  assign free  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && ready);
  assign valid = (cnt_r != 2'd0);
  assign head  = a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= step.n;
    end else if (pop) begin
      cnt_r <= (cnt_r == 2'd2) ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= step.r0;
      b_r <= step.r1;
    end else if (pop && cnt_r == 2'd2) begin
      a_r <= b_r;
    end
  end

endmodule

@@ src/keyword_statement_tokenizer.sv @@
// An accepted input beat is registered in the input register, then its result beats
// in the result register. Throughput: one text byte per cycle; a byte with results
// waits while out_tready is low or the second beat of a two-result byte drains.
// Reset (rst_n low, synchronous): tokenizer back to skipping before a keyword,
// quote flag and keyword length cleared, start/stop chars to '{' and '}'.
// Depends on kst_pkg, kst_step, kst_obuf and keyword_statement_tokenizer_defines.svh.
`include "keyword_statement_tokenizer_defines.svh"

module keyword_statement_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [9:8] record_status
  output logic [1:0]  out_tuser,  // [1:0] item_kind
  output logic        out_tlast,  // last_of_item
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             in_eot_r;
  logic [7:0]       start_r;
  logic [7:0]       stop_r;
  kst_pkg::state_t  st_r;
  kst_pkg::state_t  st_nxt;
  kst_pkg::step_t   step;
  kst_pkg::result_t head;
  logic             ob_free;
  logic             fire;

  kst_step u_step (
    .cur        (st_r),
    .start_char (start_r),
    .stop_char  (stop_r),
    .b          (in_byte_r),
    .eot        (in_eot_r),
    .nxt        (st_nxt),
    .res        (step)
  );

  // a byte with no results never waits on the result side
  assign fire      = in_vld_r && (step.n == 2'd0 || ob_free);
  assign in_tready = !in_vld_r || fire;

  kst_obuf u_obuf (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (fire && step.n != 2'd0),
    .step  (step),
    .ready (out_tready),
    .valid (out_tvalid),
    .free  (ob_free),
    .head  (head)
  );

  assign out_tdata = {6'b0, head.status, head.data};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase  <= kst_pkg::PH_SKIP;
      st_r.quotes <= 1'b0;
      st_r.klen   <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= kst_pkg::START_RST;
      stop_r  <= kst_pkg::STOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        kst_pkg::CFG_START: start_r <= cfg_wdata;
        kst_pkg::CFG_STOP:  stop_r  <= cfg_wdata;
        default:            start_r <= start_r;
      endcase
    end
  end

  `KST_ASSERT_NEXT(a_eot_clears, fire && in_eot_r, st_r.phase == kst_pkg::PH_SKIP && !st_r.quotes && st_r.klen == '0, "end of text did not clear tokenizer state")
  `KST_ASSERT_NOW(a_kw_len, st_r.phase == kst_pkg::PH_KEYWORD, st_r.klen != '0, "keyword phase with zero length")
  `KST_ASSERT_NOW(a_quotes_stmt, st_r.quotes, st_r.phase == kst_pkg::PH_STMT, "quote flag set outside a statement")
  `KST_ASSERT_NEXT(a_in_hold, in_vld_r && !fire, in_vld_r && $stable(in_byte_r) && $stable(in_eot_r), "stalled input byte lost")

endmodule
